[sv/sct_pkg.sv]
package sct_pkg;

  localparam int ActBits  = 2;
  localparam int StatBits = 2;

  // action codes of a request
  typedef enum logic [ActBits-1:0] {
    ACT_GET = 2'd0,
    ACT_SET = 2'd1,
    ACT_ACC = 2'd2
  } act_e;

  // result status codes
  typedef enum logic [StatBits-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SAT  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_COMMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;   // write an empty entry at the sweep index
    logic load;     // capture the request and restart the sweep
    logic scan_rd;  // read the entry at the sweep index
    logic calc;     // form the new value
    logic commit;   // write back and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
  } dp_sts_t;

endpackage

[sv/sct_req_if.sv]
interface sct_req_if import sct_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [ActBits-1:0]           action;
  logic [COORD_BITS-1:0]        row_index;
  logic [COORD_BITS-1:0]        col_index;
  logic signed [VALUE_BITS-1:0] operand_value;

  modport source (output valid, action, row_index, col_index, operand_value, input ready);
  modport sink (input valid, action, row_index, col_index, operand_value, output ready);
endinterface

[sv/sct_rsp_if.sv]
interface sct_rsp_if import sct_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 7
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] entry_value;
  logic                         was_present;
  logic [CNT_BITS-1:0]          nonzero_count;
  logic [StatBits-1:0]          status;

  modport source (output valid, entry_value, was_present, nonzero_count, status, input ready);
  modport sink (input valid, entry_value, was_present, nonzero_count, status, output ready);
endinterface

[sv/sparse_coordinate_table.sv]
// flow: a request is taken only while idle; a full scan of the entry memory,
//   one entry read per cycle, then compute and write-back; the next request
//   is not taken before the write-back of the last one
// reset: asynchronous, active low; afterwards a clearing pass over every entry
//   empties the table and no request is taken until it ends
module sparse_coordinate_table import sct_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  sct_req_if.sink  req_i,
  sct_rsp_if.source rsp_o
);

  // count must hold the capacity itself, index only the slots
  localparam int CntBits = $clog2(CAPACITY + 1);
  localparam int IdxBits = $clog2(CAPACITY);

  cmd_t    cmd;
  dp_sts_t sts;

  // controller: clearing pass, request sweep, compute, write-back
  sct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: entry memory, match and free-slot tracking, saturating add,
  // nonzero counter and the result register
  sct_datapath #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CntBits),
    .IDX_BITS   (IdxBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (req_i.action),
    .row_index_i     (req_i.row_index),
    .col_index_i     (req_i.col_index),
    .operand_value_i (req_i.operand_value),
    .entry_value_o   (rsp_o.entry_value),
    .was_present_o   (rsp_o.was_present),
    .nonzero_count_o (rsp_o.nonzero_count),
    .status_o        (rsp_o.status)
  );

endmodule

[sv/sct_ctrl.sv]
module sct_ctrl import sct_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.idx_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_CALC;
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.idx_last) |=> (state_q == ST_DRAIN))
    else $error("scan ran past the last entry");
`endif

endmodule

[sv/sct_datapath.sv]
module sct_datapath import sct_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 7,
  parameter int IDX_BITS   = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  output dp_sts_t                      sts_o,
  input  logic [ActBits-1:0]           action_i,
  input  logic [COORD_BITS-1:0]        row_index_i,
  input  logic [COORD_BITS-1:0]        col_index_i,
  input  logic signed [VALUE_BITS-1:0] operand_value_i,
  output logic signed [VALUE_BITS-1:0] entry_value_o,
  output logic                         was_present_o,
  output logic [CNT_BITS-1:0]          nonzero_count_o,
  output logic [StatBits-1:0]          status_o
);

  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam logic [VALUE_BITS-1:0] ValMax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] ValMin = {1'b1, {(VALUE_BITS-1){1'b0}}};

  entry_t mem_q [CAPACITY];

  logic [ActBits-1:0]    act_q;
  logic [COORD_BITS-1:0] row_q, col_q;
  logic [VALUE_BITS-1:0] opv_q;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  entry_t                rd_q;
  logic                  rd_vld_q;
  logic [IDX_BITS-1:0]   rd_idx_q;
  logic                  hit_q, free_q;
  logic [IDX_BITS-1:0]   hit_idx_q, free_idx_q;
  logic [VALUE_BITS-1:0] old_q, nv_q;
  logic                  sat_q;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [VALUE_BITS-1:0] ev_q;
  logic                  wp_q;
  stat_e                 stat_q;

  logic [VALUE_BITS-1:0] acc_a, sum, nv_d;
  logic                  ovf;
  logic                  cm_we;
  logic [IDX_BITS-1:0]   cm_addr;
  entry_t                cm_data;
  logic [VALUE_BITS-1:0] res;
  stat_e                 stat_d;
  logic                  is_wr;

  assign sts_o.idx_last = (idx_q == IDX_BITS'(CAPACITY - 1));

  // sweep index, shared by the clearing pass and the scan
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) idx_d = '0;
    else if (cmd_i.clr_wr || cmd_i.scan_rd) idx_d = idx_q + 1'b1;
  end

  // saturating add for accumulate
  always_comb begin
    acc_a = hit_q ? old_q : '0;
    sum   = acc_a + opv_q;
    ovf   = (acc_a[VALUE_BITS-1] == opv_q[VALUE_BITS-1]) &&
            (sum[VALUE_BITS-1] != acc_a[VALUE_BITS-1]);
    nv_d  = opv_q;
    if (act_q == ACT_ACC) nv_d = ovf ? (acc_a[VALUE_BITS-1] ? ValMin : ValMax) : sum;
  end

  // write-back decision
  always_comb begin
    is_wr   = (act_q == ACT_SET) || (act_q == ACT_ACC);
    cm_we   = 1'b0;
    cm_addr = hit_idx_q;
    cm_data = '{valid: 1'b1, row: row_q, col: col_q, value: nv_q};
    count_d = count_q;
    res     = hit_q ? old_q : '0;
    stat_d  = STAT_OK;
    if (is_wr) begin
      stat_d = sat_q ? STAT_SAT : STAT_OK;
      if (nv_q == '0) begin
        res = '0;
        if (hit_q) begin
          cm_we         = 1'b1;
          cm_data.valid = 1'b0;
          count_d       = count_q - 1'b1;
        end
      end else if (hit_q) begin
        cm_we = 1'b1;
        res   = nv_q;
      end else if (free_q) begin
        cm_we   = 1'b1;
        cm_addr = free_idx_q;
        count_d = count_q + 1'b1;
        res     = nv_q;
      end else begin
        stat_d = STAT_FULL;
        res    = '0;
      end
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) mem_q[idx_q] <= '0;
    else if (cmd_i.commit && cm_we) mem_q[cm_addr] <= cm_data;
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      count_q  <= '0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_q.valid && rd_q.row == row_q && rd_q.col == col_q) hit_q <= 1'b1;
        if (!rd_q.valid) free_q <= 1'b1;
      end
      if (cmd_i.commit) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      act_q <= action_i;
      row_q <= row_index_i;
      col_q <= col_index_i;
      opv_q <= operand_value_i;
    end
    if (rd_vld_q) begin
      if (rd_q.valid && rd_q.row == row_q && rd_q.col == col_q) begin
        hit_idx_q <= rd_idx_q;
        old_q     <= rd_q.value;
      end
      if (!rd_q.valid && !free_q) free_idx_q <= rd_idx_q;
    end
    if (cmd_i.calc) begin
      nv_q  <= nv_d;
      sat_q <= (act_q == ACT_ACC) && ovf;
    end
    if (cmd_i.commit) begin
      ev_q   <= res;
      wp_q   <= hit_q;
      stat_q <= stat_d;
    end
  end

  assign entry_value_o   = ev_q;
  assign was_present_o   = wp_q;
  assign nonzero_count_o = count_q;
  assign status_o        = stat_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(CAPACITY))
    else $error("nonzero count above capacity");
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_wr && (cmd_i.scan_rd || cmd_i.commit || cmd_i.load)))
    else $error("clearing pass overlaps request work");
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(count_q))
    else $error("nonzero count moved outside write-back");
`endif

endmodule
